/* src/lif_pkg.sv */
// Shared types and constants for the leaky integrate-and-fire neuron bank.
`timescale 1ns / 1ps

package lif_pkg;

  localparam int unsigned ID_W     = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD        = 3'd0,
    REG_RESET_LEVEL      = 3'd1,
    REG_REST_LEVEL       = 3'd2,
    REG_INPUT_GAIN       = 3'd3,
    REG_STEP_GAIN        = 3'd4,
    REG_REFRACTORY_STEPS = 3'd5,
    REG_OUTPUT_SCALE     = 3'd6
  } lif_cfg_idx_e;

  // Register reset values
  localparam logic signed [DATA_W-1:0] THRESHOLD_RST   = 32'sd327680;
  localparam logic signed [DATA_W-1:0] RESET_LEVEL_RST = -32'sd327680;
  localparam logic signed [DATA_W-1:0] REST_LEVEL_RST  = -32'sd327680;
  localparam logic [DATA_W-1:0]        INPUT_GAIN_RST  = 32'd65536;
  localparam logic [DATA_W-1:0]        STEP_GAIN_RST   = 32'd42949673;
  localparam logic [HOLD_W-1:0]        REFRACT_RST     = 16'd20;
  localparam logic [DATA_W-1:0]        OUT_SCALE_RST   = 32'd65536;

  // Membrane value of a neuron that was never updated (-5.0)
  localparam logic signed [DATA_W-1:0] MEMBRANE_RST = -32'sd327680;
  // Offset taken off the scaled output (5.0)
  localparam logic signed [DATA_W-1:0] SCALE_OFFSET = 32'sd327680;

  typedef struct packed {
    logic signed [DATA_W-1:0] threshold;
    logic signed [DATA_W-1:0] reset_level;
    logic signed [DATA_W-1:0] rest_level;
    logic [DATA_W-1:0]        input_gain;
    logic [DATA_W-1:0]        step_gain;
    logic [HOLD_W-1:0]        refractory_steps;
    logic [DATA_W-1:0]        output_scale;
  } lif_cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]          neuron_id;
    logic signed [DATA_W-1:0] current;
  } lif_item_t;

endpackage

/* src/lif_front.sv */
// Input side: accept items, map the index to a bank slot, queue them for the back end.
`timescale 1ns / 1ps

module lif_front import lif_pkg::*; #(
  parameter int unsigned NEURONS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ID_W-1:0]                   neuron_index_i,
  input  logic signed [DATA_W-1:0]          input_current_i,
  output logic                              q_valid_o,
  output lif_item_t                         q_item_o,
  output logic [((NEURONS > 1) ? $clog2(NEURONS) : 1)-1:0] q_slot_o,
  input  logic                              q_pop_i
);

  localparam int unsigned SlotW   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned IdCount = 1 << ID_W;

  // Slot lookup: index modulo bank size, fixed at elaboration
  logic [SlotW-1:0] slot_tbl [IdCount];
  for (genvar i = 0; i < IdCount; i++) begin : g_slot
    localparam int unsigned SlotVal = i % NEURONS;
    assign slot_tbl[i] = SlotW'(SlotVal);
  end

  // Two-entry queue
  lif_item_t        item_q [2];
  logic [SlotW-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = item_q[rd_ptr_q];
  assign q_slot_o   = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (q_pop_i && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the accepted item with its slot
  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q].neuron_id <= neuron_index_i;
      item_q[wr_ptr_q].current   <= input_current_i;
      slot_q[wr_ptr_q]           <= slot_tbl[neuron_index_i];
    end
  end

endmodule

/* src/lif_back.sv */
// Back end: per-neuron state memory and the multi-cycle membrane update sequencer.
`timescale 1ns / 1ps

module lif_back import lif_pkg::*; #(
  parameter int unsigned NEURONS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lif_cfg_t                          cfg_i,
  input  logic                              q_valid_i,
  input  lif_item_t                         q_item_i,
  input  logic [((NEURONS > 1) ? $clog2(NEURONS) : 1)-1:0] q_slot_i,
  output logic                              q_pop_o,
  output logic                              busy_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ID_W-1:0]                   neuron_id_o,
  output logic                              spike_fired_o,
  output logic signed [DATA_W-1:0]          membrane_level_o,
  output logic signed [DATA_W-1:0]          scaled_level_o
);

  localparam int unsigned SlotW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned WordW = HOLD_W + DATA_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECIDE = 8'b0000_0010,
    ST_SUM    = 8'b0000_0100,
    ST_MUL    = 8'b0000_1000,
    ST_ACC    = 8'b0001_0000,
    ST_UPD    = 8'b0010_0000,
    ST_SCALE  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } lif_state_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  lif_state_e st_q, st_d;

  // State memory and per-entry written flags
  logic [WordW-1:0]   mem_q [NEURONS];
  logic [NEURONS-1:0] ok_q;
  logic [WordW-1:0]   rd_word_q;
  logic               rd_ok_q;

  // Item payload and datapath registers
  logic [ID_W-1:0]          id_q;
  logic [SlotW-1:0]         slot_q;
  logic signed [DATA_W-1:0] cur_q;
  logic                     fired_q;
  logic signed [DATA_W-1:0] v_eff_q;
  logic [HOLD_W-1:0]        hold_q;
  logic signed [64:0]       p_q;
  logic signed [50:0]       s_q;
  logic signed [66:0]       t_q;
  logic [48:0]              b_q;
  logic signed [66:0]       acc_q;
  logic signed [DATA_W-1:0] vn_q;
  logic signed [65:0]       prod_q;

  logic                     out_valid_q;
  logic [ID_W-1:0]          out_id_q;
  logic                     out_fired_q;
  logic signed [DATA_W-1:0] out_v_q;
  logic signed [DATA_W-1:0] out_sc_q;

  logic                     out_load;
  logic                     pop;
  logic signed [DATA_W-1:0] v_old;
  logic [HOLD_W-1:0]        hold_old;
  logic signed [DATA_W-1:0] vn_d;
  logic signed [52:0]       v_sum;
  logic signed [33:0]       s_hi;
  logic signed [32:0]       x_rel;
  logic signed [DATA_W-1:0] sc_d;

  assign out_load = (st_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign pop      = q_valid_i && ((st_q == ST_IDLE) || out_load);
  assign q_pop_o  = pop;
  assign busy_o   = (st_q != ST_IDLE);

  // Unwritten entries read as reset state
  assign v_old    = rd_ok_q ? $signed(rd_word_q[DATA_W-1:0]) : MEMBRANE_RST;
  assign hold_old = rd_ok_q ? rd_word_q[WordW-1:DATA_W] : '0;

  assign s_hi  = 34'(s_q >>> 17);
  assign v_sum = 53'(v_eff_q) + 53'(acc_q >>> 15);
  assign vn_d  = sat32(64'(v_sum));
  assign x_rel = 33'(vn_q) - 33'($signed(cfg_i.reset_level));
  assign sc_d  = sat32(64'(prod_q >>> 16) - 64'(SCALE_OFFSET));

  // Sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (pop) st_d = ST_DECIDE;
      ST_DECIDE: st_d = ST_SUM;
      ST_SUM:    st_d = ST_MUL;
      ST_MUL:    st_d = ST_ACC;
      ST_ACC:    st_d = ST_UPD;
      ST_UPD:    st_d = ST_SCALE;
      ST_SCALE:  st_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          st_d = pop ? ST_DECIDE : ST_IDLE;
        end
      end
      default:   st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ok_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_UPD) begin
        ok_q[slot_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory: read on pop, write back on update
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_word_q <= mem_q[q_slot_i];
      rd_ok_q   <= ok_q[q_slot_i];
    end
    if (st_q == ST_UPD) begin
      mem_q[slot_q] <= {hold_q, vn_d};
    end
  end

  // Datapath steps
  always_ff @(posedge clk_i) begin
    if (pop) begin
      id_q   <= q_item_i.neuron_id;
      cur_q  <= q_item_i.current;
      slot_q <= q_slot_i;
    end
    case (st_q)
      ST_DECIDE: begin
        // Hold, fire or pass, and scale the input current
        if (hold_old != '0) begin
          hold_q  <= hold_old - HOLD_W'(1);
          v_eff_q <= $signed(cfg_i.reset_level);
          fired_q <= 1'b0;
        end else if (v_old >= $signed(cfg_i.threshold)) begin
          hold_q  <= cfg_i.refractory_steps;
          v_eff_q <= $signed(cfg_i.reset_level);
          fired_q <= 1'b1;
        end else begin
          hold_q  <= hold_old;
          v_eff_q <= v_old;
          fired_q <= 1'b0;
        end
        p_q <= cur_q * $signed({1'b0, cfg_i.input_gain});
      end
      ST_SUM: begin
        s_q <= 51'($signed(cfg_i.rest_level)) - 51'(v_eff_q) + 51'(p_q >>> 16);
      end
      ST_MUL: begin
        // Split the leak term into high and low partial products
        t_q <= s_hi * $signed({1'b0, cfg_i.step_gain});
        b_q <= s_q[16:0] * cfg_i.step_gain;
      end
      ST_ACC: begin
        acc_q <= t_q + $signed({35'b0, b_q[48:17]});
      end
      ST_UPD: begin
        vn_q <= vn_d;
      end
      ST_SCALE: begin
        prod_q <= x_rel * $signed({1'b0, cfg_i.output_scale});
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q    <= id_q;
      out_fired_q <= fired_q;
      out_v_q     <= vn_q;
      out_sc_q    <= sc_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign neuron_id_o      = out_id_q;
  assign spike_fired_o    = out_fired_q;
  assign membrane_level_o = out_v_q;
  assign scaled_level_o   = out_sc_q;

endmodule

/* src/leaky_integrate_fire_neuron_top.sv */
// Bank of leaky integrate-and-fire neurons with a queued front end and a sequential back end.
// The back-end update sequencer handles one item at a time (state memory read,
// two multiply passes, write back, output scaling) and takes the next item as it
// loads the result into the output register; an output stall holds it back.
// Reset clears the control state and loads the register defaults; every neuron
// reads as -5.0 with no hold until first updated.
`timescale 1ns / 1ps

module leaky_integrate_fire_neuron_top import lif_pkg::*; #(
  parameter int unsigned NEURONS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ID_W-1:0]          neuron_index_i,
  input  logic signed [DATA_W-1:0] input_current_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ID_W-1:0]          neuron_id_o,
  output logic                     spike_fired_o,
  output logic signed [DATA_W-1:0] membrane_level_o,
  output logic signed [DATA_W-1:0] scaled_level_o
);

  localparam int unsigned SlotW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  lif_cfg_t         cfg_q;
  logic             q_valid;
  lif_item_t        q_item;
  logic [SlotW-1:0] q_slot;
  logic             q_pop;
  logic             back_busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold        <= THRESHOLD_RST;
      cfg_q.reset_level      <= RESET_LEVEL_RST;
      cfg_q.rest_level       <= REST_LEVEL_RST;
      cfg_q.input_gain       <= INPUT_GAIN_RST;
      cfg_q.step_gain        <= STEP_GAIN_RST;
      cfg_q.refractory_steps <= REFRACT_RST;
      cfg_q.output_scale     <= OUT_SCALE_RST;
    end else if (cfg_we_i) begin
      case (lif_cfg_idx_e'(cfg_index_i))
        REG_THRESHOLD:        cfg_q.threshold        <= cfg_data_i;
        REG_RESET_LEVEL:      cfg_q.reset_level      <= cfg_data_i;
        REG_REST_LEVEL:       cfg_q.rest_level       <= cfg_data_i;
        REG_INPUT_GAIN:       cfg_q.input_gain       <= cfg_data_i;
        REG_STEP_GAIN:        cfg_q.step_gain        <= cfg_data_i;
        REG_REFRACTORY_STEPS: cfg_q.refractory_steps <= cfg_data_i[HOLD_W-1:0];
        REG_OUTPUT_SCALE:     cfg_q.output_scale     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lif_front #(
    .NEURONS(NEURONS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .neuron_index_i  (neuron_index_i),
    .input_current_i (input_current_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_slot_o        (q_slot),
    .q_pop_i         (q_pop)
  );

  lif_back #(
    .NEURONS(NEURONS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_slot_i         (q_slot),
    .q_pop_o          (q_pop),
    .busy_o           (back_busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .neuron_id_o      (neuron_id_o),
    .spike_fired_o    (spike_fired_o),
    .membrane_level_o (membrane_level_o),
    .scaled_level_o   (scaled_level_o)
  );

`ifndef NO_ASSERTIONS
  // Back end only takes an item that the queue presents
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // A popped item keeps the back end busy on the next cycle
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> back_busy) else $error("popped item not in work");

  // A full queue always offers an item to the back end
  a_full_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid) else $error("stall with empty queue");

  // A new result only comes out of a busy back end
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_busy)) else $error("result without work");
`endif

endmodule

/* tb/lif_neuron_checker.sv */
// Checker for the neuron bank: mirrors membrane state and compares every result item.
`timescale 1ns / 1ps

module lif_neuron_checker import lif_pkg::*; #(
  parameter int unsigned NEURONS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [ID_W-1:0]          neuron_index_i,
  input  logic signed [DATA_W-1:0] input_current_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [ID_W-1:0]          neuron_id_i,
  input  logic                     spike_fired_i,
  input  logic signed [DATA_W-1:0] membrane_level_i,
  input  logic signed [DATA_W-1:0] scaled_level_i,
  output int unsigned              outstanding_o,
  output int unsigned              mismatches_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [ID_W-1:0]          neuron_id;
    logic                     spike_fired;
    logic signed [DATA_W-1:0] membrane_level;
    logic signed [DATA_W-1:0] scaled_level;
  } neuron_update_t;

  // Local copy of the registers
  logic signed [DATA_W-1:0] fire_level;
  logic signed [DATA_W-1:0] reset_v;
  logic signed [DATA_W-1:0] rest_v;
  logic [DATA_W-1:0]        drive_gain;
  logic [DATA_W-1:0]        step_frac;
  logic [HOLD_W-1:0]        hold_steps;
  logic [DATA_W-1:0]        out_gain;

  // Local copy of the neuron state
  logic signed [DATA_W-1:0] membrane [NEURONS];
  logic [HOLD_W-1:0]        hold_left [NEURONS];

  neuron_update_t pending_updates[$];
  int unsigned    mismatch_count;

  function automatic logic signed [DATA_W-1:0] clamp_word(input wide_t x);
    if (x > wide_t'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (x < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
    return x[DATA_W-1:0];
  endfunction

  // Apply one current sample to one neuron and return the result it should produce
  function automatic neuron_update_t advance_neuron(input logic [ID_W-1:0] idx,
                                                    input logic signed [DATA_W-1:0] cur);
    int unsigned    slot;
    wide_t          v;
    wide_t          drive;
    wide_t          gap;
    wide_t          scaled;
    neuron_update_t r;
    slot          = idx % NEURONS;
    r.neuron_id   = idx;
    r.spike_fired = 1'b0;
    v             = membrane[slot];
    // Count the hold down and pin the membrane, or fire on the level from before this item
    if (hold_left[slot] != '0) begin
      hold_left[slot] = hold_left[slot] - 1'b1;
      v = reset_v;
    end else if (v >= wide_t'(fire_level)) begin
      r.spike_fired   = 1'b1;
      v               = reset_v;
      hold_left[slot] = hold_steps;
    end
    // Leak toward rest plus the gained input, each product floored
    drive = (wide_t'(cur) * wide_t'(drive_gain)) >>> 16;
    gap   = wide_t'(rest_v) - v + drive;
    v     = clamp_word(v + ((gap * wide_t'(step_frac)) >>> 32));
    membrane[slot] = v[DATA_W-1:0];
    // Rescale relative to the reset level and take off the 5.0 offset
    scaled = (((v - wide_t'(reset_v)) * wide_t'(out_gain)) >>> 16) - wide_t'(SCALE_OFFSET);
    r.membrane_level = v[DATA_W-1:0];
    r.scaled_level   = clamp_word(scaled);
    return r;
  endfunction

  function automatic int unsigned field_differs(input string name,
                                                input logic [DATA_W-1:0] want,
                                                input logic [DATA_W-1:0] got);
    if (got === want) return 0;
    $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    neuron_update_t want;
    int             n;
    if (!rst_ni) begin
      fire_level = THRESHOLD_RST;
      reset_v    = RESET_LEVEL_RST;
      rest_v     = REST_LEVEL_RST;
      drive_gain = INPUT_GAIN_RST;
      step_frac  = STEP_GAIN_RST;
      hold_steps = REFRACT_RST;
      out_gain   = OUT_SCALE_RST;
      for (n = 0; n < NEURONS; n++) begin
        membrane[n]  = MEMBRANE_RST;
        hold_left[n] = '0;
      end
      pending_updates.delete();
      mismatch_count = 0;
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_THRESHOLD:        fire_level = cfg_data_i;
          REG_RESET_LEVEL:      reset_v    = cfg_data_i;
          REG_REST_LEVEL:       rest_v     = cfg_data_i;
          REG_INPUT_GAIN:       drive_gain = cfg_data_i;
          REG_STEP_GAIN:        step_frac  = cfg_data_i;
          REG_REFRACTORY_STEPS: hold_steps = cfg_data_i[HOLD_W-1:0];
          REG_OUTPUT_SCALE:     out_gain   = cfg_data_i;
          default: ;
        endcase
      end
      // Predict on every accepted input item
      if (in_valid_i && !in_stall_i)
        pending_updates.push_back(advance_neuron(neuron_index_i, input_current_i));
      // Compare every accepted result item with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pending_updates.size() == 0) begin
          $display("%0t: unexpected result, expected none actual id %h membrane %h",
                   $time, neuron_id_i, membrane_level_i);
          mismatch_count++;
        end else begin
          want = pending_updates.pop_front();
          mismatch_count += field_differs("neuron_id", DATA_W'(want.neuron_id),
                                          DATA_W'(neuron_id_i));
          mismatch_count += field_differs("spike_fired", DATA_W'(want.spike_fired),
                                          DATA_W'(spike_fired_i));
          mismatch_count += field_differs("membrane_level", want.membrane_level,
                                          membrane_level_i);
          mismatch_count += field_differs("scaled_level", want.scaled_level,
                                          scaled_level_i);
        end
      end
      outstanding_o <= pending_updates.size();
      mismatches_o  <= mismatch_count;
    end
  end

endmodule

/* tb/leaky_integrate_fire_neuron_top_tb.sv */
// Testbench top for the neuron bank: drives items and registers, and reports the verdict.
`timescale 1ns / 1ps

module leaky_integrate_fire_neuron_top_tb;

  import lif_pkg::*;

  localparam int unsigned LIMIT        = 300000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 12;
  // Index past the last register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index     = '0;
  logic [DATA_W-1:0]        cfg_data      = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [ID_W-1:0]          neuron_index  = '0;
  logic signed [DATA_W-1:0] input_current = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [ID_W-1:0]          neuron_id;
  logic                     spike_fired;
  logic signed [DATA_W-1:0] membrane_level;
  logic signed [DATA_W-1:0] scaled_level;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned cycles    = 0;
  logic        calm      = 1'b0;
  logic        long_hold = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  leaky_integrate_fire_neuron_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .neuron_index_i   (neuron_index),
    .input_current_i  (input_current),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .neuron_id_o      (neuron_id),
    .spike_fired_o    (spike_fired),
    .membrane_level_o (membrane_level),
    .scaled_level_o   (scaled_level)
  );

  lif_neuron_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .neuron_index_i   (neuron_index),
    .input_current_i  (input_current),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .neuron_id_i      (neuron_id),
    .spike_fired_i    (spike_fired),
    .membrane_level_i (membrane_level),
    .scaled_level_i   (scaled_level),
    .outstanding_o    (outstanding),
    .mismatches_o     (mismatches)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one item, with a random gap in front, and hold it until accepted
  task automatic send_item(input logic [ID_W-1:0] idx, input logic signed [DATA_W-1:0] cur);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    neuron_index  <= idx;
    input_current <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait for every result plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write every register, plus one write to the unused index
  task automatic load_settings(input lif_cfg_t c);
    put_reg(REG_THRESHOLD, c.threshold);
    put_reg(REG_RESET_LEVEL, c.reset_level);
    put_reg(REG_REST_LEVEL, c.rest_level);
    put_reg(REG_INPUT_GAIN, c.input_gain);
    put_reg(REG_STEP_GAIN, c.step_gain);
    put_reg(REG_REFRACTORY_STEPS, {16'($urandom), c.refractory_steps});
    put_reg(REG_OUTPUT_SCALE, c.output_scale);
    put_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stall bursts, one long hold-off, and none once calm
  initial begin
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    lif_cfg_t                 setting;
    logic [ID_W-1:0]          idx;
    logic signed [DATA_W-1:0] cur;
    int                       phase;
    int                       k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: push neuron 0 over threshold, see it fire, then hold
    send_item(4'd0, 32'sh7fff_ffff);
    send_item(4'd0, '0);
    send_item(4'd0, '0);
    send_item(4'd1, 32'sh8000_0000);
    send_item(4'd15, -32'sd1);
    send_item(4'd15, 32'sd1);
    send_item(4'd2, '0);
    send_item(4'd6, 32'sh0001_0000);
    settle();

    // Every register at an extreme: fire at any level, saturate, longest hold
    setting.threshold        = 32'sh8000_0000;
    setting.reset_level      = 32'sh7fff_ffff;
    setting.rest_level       = 32'sh8000_0000;
    setting.input_gain       = 32'hffff_ffff;
    setting.step_gain        = 32'hffff_ffff;
    setting.refractory_steps = 16'hffff;
    setting.output_scale     = 32'hffff_ffff;
    load_settings(setting);
    send_item(4'd3, 32'sh7fff_ffff);
    send_item(4'd3, 32'sh8000_0000);
    send_item(4'd7, 32'sh8000_0000);
    send_item(4'd8, '0);
    send_item(4'd9, -32'sd1);
    send_item(4'd10, 32'sh7fff_ffff);
    settle();

    // Threshold equal to the reset level, frozen membrane, zero hold: fire on every item
    setting.threshold        = -32'sd327680;
    setting.reset_level      = -32'sd327680;
    setting.rest_level       = 32'sh7fff_ffff;
    setting.input_gain       = '0;
    setting.step_gain        = '0;
    setting.refractory_steps = '0;
    setting.output_scale     = '0;
    load_settings(setting);
    send_item(4'd4, 32'sh7fff_ffff);
    send_item(4'd4, 32'sh8000_0000);
    send_item(4'd5, '0);
    send_item(4'd11, 32'sh1234_5678);
    settle();

    // Random registers, mostly sane so that neurons cycle through fire and hold
    for (phase = 0; phase < 6; phase++) begin
      if ($urandom_range(0, 2) == 0) begin
        setting.threshold        = $urandom;
        setting.reset_level      = $urandom;
        setting.rest_level       = $urandom;
        setting.input_gain       = $urandom;
        setting.step_gain        = $urandom;
        setting.refractory_steps = 16'($urandom);
        setting.output_scale     = $urandom;
      end else begin
        setting.threshold        = $urandom_range(0, 655360) - 196608;
        setting.reset_level      = -$urandom_range(0, 655360);
        setting.rest_level       = setting.reset_level + $urandom_range(0, 131072) - 65536;
        setting.input_gain       = $urandom_range(16384, 262144);
        setting.step_gain        = $urandom_range(42949673, 1073741824);
        setting.refractory_steps = 16'($urandom_range(0, 6));
        setting.output_scale     = $urandom_range(0, 262144);
      end
      load_settings(setting);
      if (phase == 1) long_hold = 1'b1;
      calm = (phase == 5);
      for (k = 0; k < 125; k++) begin
        idx = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0, 1:    cur = $urandom;
          2:       cur = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
          default: cur = $urandom_range(0, 1310720) - 327680;
        endcase
        send_item(idx, cur);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* leaky_integrate_fire_neuron_top.f */
src/lif_pkg.sv
src/lif_front.sv
src/lif_back.sv
src/leaky_integrate_fire_neuron_top.sv
tb/lif_neuron_checker.sv
tb/leaky_integrate_fire_neuron_top_tb.sv
